// ===== design/kwtl_pkg.sv =====
// keyword token lexer package: token kinds, separator codes, keyword table,
// queue entry type and helper functions
// no dependencies; used by every kwtl module
`timescale 1ns / 1ps
`default_nettype none

package kwtl_pkg;

    // word length limit and internal widths
    localparam int MAX_WORD   = 16;
    localparam int LEN_W      = 5;
    localparam int TEXT_BYTES = 8;
    localparam int TEXT_W     = 8 * TEXT_BYTES;
    localparam int KW_CHARS   = 16;
    localparam int KW_TXT_W   = 8 * KW_CHARS;
    localparam int KW_COUNT   = 20;

    // queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [3:0] KIND_INITIAL  = 4'd0;
    localparam logic [3:0] KIND_FINAL    = 4'd1;
    localparam logic [3:0] KIND_DATA     = 4'd2;
    localparam logic [3:0] KIND_ALGO     = 4'd3;
    localparam logic [3:0] KIND_CMD_VAL  = 4'd4;
    localparam logic [3:0] KIND_CMD_NVAL = 4'd5;
    localparam logic [3:0] KIND_KEYWORD  = 4'd6;
    localparam logic [3:0] KIND_INT      = 4'd7;
    localparam logic [3:0] KIND_DOUBLE   = 4'd8;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd9;
    localparam logic [3:0] KIND_SEP      = 4'd10;

    // separator codes
    localparam logic [2:0] SEP_SEMI  = 3'd0;
    localparam logic [2:0] SEP_UNDER = 3'd1;
    localparam logic [2:0] SEP_OPEN  = 3'd2;
    localparam logic [2:0] SEP_CLOSE = 3'd3;
    localparam logic [2:0] SEP_COMMA = 3'd4;

    // character codes
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // keyword table entry: text right aligned, first character highest
    typedef struct packed {
        logic [KW_TXT_W-1:0] txt;
        logic [3:0]          len;
        logic [3:0]          kind;
        logic [2:0]          idx;
    } t_kw_entry;

    localparam t_kw_entry KW_TABLE [KW_COUNT] = '{
        '{KW_TXT_W'("create"),     4'd6,  KIND_INITIAL,  3'd0},
        '{KW_TXT_W'("draw"),       4'd4,  KIND_FINAL,    3'd0},
        '{KW_TXT_W'("binaryTree"), 4'd10, KIND_DATA,     3'd0},
        '{KW_TXT_W'("graph"),      4'd5,  KIND_DATA,     3'd1},
        '{KW_TXT_W'("stack"),      4'd5,  KIND_DATA,     3'd2},
        '{KW_TXT_W'("queue"),      4'd5,  KIND_DATA,     3'd3},
        '{KW_TXT_W'("inorder"),    4'd7,  KIND_ALGO,     3'd0},
        '{KW_TXT_W'("preorder"),   4'd8,  KIND_ALGO,     3'd1},
        '{KW_TXT_W'("postorder"),  4'd9,  KIND_ALGO,     3'd2},
        '{KW_TXT_W'("add"),        4'd3,  KIND_CMD_VAL,  3'd0},
        '{KW_TXT_W'("delete"),     4'd6,  KIND_CMD_VAL,  3'd1},
        '{KW_TXT_W'("find"),       4'd4,  KIND_CMD_VAL,  3'd2},
        '{KW_TXT_W'("push"),       4'd4,  KIND_CMD_VAL,  3'd3},
        '{KW_TXT_W'("pop"),        4'd3,  KIND_CMD_NVAL, 3'd0},
        '{KW_TXT_W'("front"),      4'd5,  KIND_CMD_NVAL, 3'd1},
        '{KW_TXT_W'("back"),       4'd4,  KIND_CMD_NVAL, 3'd2},
        '{KW_TXT_W'("empty"),      4'd5,  KIND_CMD_NVAL, 3'd3},
        '{KW_TXT_W'("top"),        4'd3,  KIND_CMD_NVAL, 3'd4},
        '{KW_TXT_W'("node"),       4'd4,  KIND_KEYWORD,  3'd0},
        '{KW_TXT_W'("tree"),       4'd4,  KIND_KEYWORD,  3'd1}
    };

    // one classified separator, with the word that precedes it if any
    typedef struct packed {
        logic              has_word;
        logic [3:0]        kind;
        logic [2:0]        idx;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
        logic              too_long;
        logic [2:0]        sep_idx;
    } t_tok_entry;

    // push request from front to queue
    typedef struct packed {
        logic       valid;
        t_tok_entry entry;
    } t_push;

    // head of queue toward back
    typedef struct packed {
        logic       valid;
        t_tok_entry entry;
    } t_head;

    // character of a keyword at a position below its length
    function automatic logic [7:0] kw_char(input t_kw_entry e, input logic [3:0] pos);
        logic [3:0] sel;
        sel = e.len - 4'd1 - pos;
        return e.txt[{sel, 3'b000} +: 8];
    endfunction

    // separator detection
    function automatic logic is_sep(input logic [7:0] c);
        return c inside {CH_SEMI, CH_UNDER, CH_OPEN, CH_CLOSE, CH_COMMA};
    endfunction

    // separator code of a separator character
    function automatic logic [2:0] sep_code(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            CH_SEMI:  code = SEP_SEMI;
            CH_UNDER: code = SEP_UNDER;
            CH_OPEN:  code = SEP_OPEN;
            CH_CLOSE: code = SEP_CLOSE;
            CH_COMMA: code = SEP_COMMA;
            default:  code = SEP_SEMI;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== design/kwtl_front.sv =====
// front of the lexer: takes characters, builds the current word with
// incremental keyword matching, classifies it at a separator
// depends on kwtl_pkg
`timescale 1ns / 1ps
`default_nettype none

module kwtl_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic [7:0]     i_char_in,
    input  wire logic           i_q_full,
    output logic                o_in_ready,
    output kwtl_pkg::t_push     o_push
);
    import kwtl_pkg::*;

    // word state
    logic [LEN_W-1:0]    r_len,   n_len;
    logic                r_dot,   n_dot;
    logic                r_brk,   n_brk;
    logic [KW_COUNT-1:0] r_match, n_match;
    logic [TEXT_W-1:0]   r_text,  n_text;

    logic       w_acc;
    logic       w_sep;
    logic       w_tl;
    logic [LEN_W-1:0] w_len;
    logic       w_found;
    logic [3:0] w_kind;
    logic [2:0] w_idx;
    t_tok_entry w_entry;

    assign o_in_ready = !i_q_full;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_sep      = is_sep(i_char_in);

    // classify the buffered word
    always_comb begin
        w_tl    = r_len > LEN_W'(MAX_WORD);
        w_len   = w_tl ? LEN_W'(MAX_WORD) : r_len;
        w_found = 1'b0;
        w_kind  = KIND_UNKNOWN;
        w_idx   = 3'd0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!w_found && r_match[i] && (r_len == LEN_W'(KW_TABLE[i].len))) begin
                w_found = 1'b1;
                w_kind  = KW_TABLE[i].kind;
                w_idx   = KW_TABLE[i].idx;
            end
        end
        w_entry          = '0;
        w_entry.has_word = r_len != '0;
        w_entry.len      = w_len;
        w_entry.too_long = w_tl;
        w_entry.sep_idx  = sep_code(i_char_in);
        if (r_brk) begin
            w_entry.kind = r_dot ? KIND_DOUBLE : KIND_INT;
            w_entry.text = r_text;
        end else begin
            w_entry.kind = w_kind;
            w_entry.idx  = w_idx;
        end
    end

    // next word state
    always_comb begin
        n_len   = r_len;
        n_dot   = r_dot;
        n_brk   = r_brk;
        n_match = r_match;
        n_text  = r_text;
        if (w_acc) begin
            if (w_sep) begin
                n_len   = '0;
                n_dot   = 1'b0;
                n_match = '1;
                n_text  = '0;
                if (i_char_in == CH_OPEN) begin
                    n_brk = 1'b1;
                end else if (i_char_in == CH_CLOSE) begin
                    n_brk = 1'b0;
                end
            end else begin
                if (r_len <= LEN_W'(MAX_WORD)) begin
                    n_len = r_len + LEN_W'(1);
                end
                if (i_char_in == CH_DOT) begin
                    n_dot = 1'b1;
                end
                if (r_len < LEN_W'(TEXT_BYTES)) begin
                    n_text[{r_len[2:0], 3'b000} +: 8] = i_char_in;
                end
                for (int i = 0; i < KW_COUNT; i++) begin
                    n_match[i] = r_match[i] && (r_len < LEN_W'(KW_TABLE[i].len)) &&
                                 (i_char_in == kw_char(KW_TABLE[i], r_len[3:0]));
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_dot   <= 1'b0;
            r_brk   <= 1'b0;
            r_match <= '1;
            r_text  <= '0;
        end else begin
            r_len   <= n_len;
            r_dot   <= n_dot;
            r_brk   <= n_brk;
            r_match <= n_match;
            r_text  <= n_text;
        end
    end

    // push request for every accepted separator
    assign o_push = {w_acc && w_sep, w_entry};

endmodule

`default_nettype wire

// ===== design/kwtl_queue.sv =====
// short queue of classified separators between front and back
// depends on kwtl_pkg
`timescale 1ns / 1ps
`default_nettype none

module kwtl_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire kwtl_pkg::t_push i_push,
    input  wire logic            i_pop,
    output logic                 o_full,
    output kwtl_pkg::t_head      o_head
);
    import kwtl_pkg::*;

    t_tok_entry         r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               w_pop;

    assign o_full = r_cnt == QCNT_W'(QDEPTH);
    assign w_pop  = i_pop && (r_cnt != '0);
    assign o_head = {r_cnt != '0, r_mem[r_rd]};

    // pointer and count update
    always_comb begin
        n_wr  = i_push.valid ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = w_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt;
        if (i_push.valid && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push.valid && w_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    // no push into a full queue unless it pops in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_full && !i_pop))
        else $error("push into full queue");

    // count agrees with pointer distance
    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wr - r_rd) == r_cnt[QPTR_W-1:0])
        else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

// ===== design/kwtl_back.sv =====
// back of the lexer: turns queue entries into one or two result tokens
// and holds them in an output register
// depends on kwtl_pkg
`timescale 1ns / 1ps
`default_nettype none

module kwtl_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire kwtl_pkg::t_head               i_head,
    input  wire logic                          i_out_ready,
    output logic                               o_pop,
    output logic                               o_out_valid,
    output logic [3:0]                         o_token_kind,
    output logic [2:0]                         o_token_index,
    output logic [kwtl_pkg::TEXT_W-1:0]        o_value_text,
    output logic [kwtl_pkg::LEN_W-1:0]         o_text_length,
    output logic                               o_too_long,
    output logic                               o_last
);
    import kwtl_pkg::*;

    logic              r_valid, n_valid;
    logic              r_word_done, n_word_done;
    logic [3:0]        r_kind, n_kind;
    logic [2:0]        r_idx, n_idx;
    logic [TEXT_W-1:0] r_text, n_text;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_tl, n_tl;
    logic              r_last, n_last;
    logic              w_load;

    assign w_load = !r_valid || i_out_ready;

    // pick the next token: word first, then its separator
    always_comb begin
        n_valid     = r_valid;
        n_word_done = r_word_done;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_text      = r_text;
        n_len       = r_len;
        n_tl        = r_tl;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (w_load) begin
            n_valid = i_head.valid;
            if (i_head.valid) begin
                if (i_head.entry.has_word && !r_word_done) begin
                    n_word_done = 1'b1;
                    n_kind      = i_head.entry.kind;
                    n_idx       = i_head.entry.idx;
                    n_text      = i_head.entry.text;
                    n_len       = i_head.entry.len;
                    n_tl        = i_head.entry.too_long;
                    n_last      = 1'b0;
                end else begin
                    n_word_done = 1'b0;
                    n_kind      = KIND_SEP;
                    n_idx       = i_head.entry.sep_idx;
                    n_text      = '0;
                    n_len       = '0;
                    n_tl        = 1'b0;
                    n_last      = 1'b1;
                    o_pop       = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_word_done <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_word_done <= n_word_done;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_text <= n_text;
        r_len  <= n_len;
        r_tl   <= n_tl;
        r_last <= n_last;
    end

    assign o_out_valid   = r_valid;
    assign o_token_kind  = r_kind;
    assign o_token_index = r_idx;
    assign o_value_text  = r_text;
    assign o_text_length = r_len;
    assign o_too_long    = r_tl;
    assign o_last        = r_last;

    // a pending separator means a word token sits in the output register
    a_word_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_done |-> (r_valid && !r_last))
        else $error("word flag set without word token held");

    // the last token of a request is always the separator
    a_last_is_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_kind == KIND_SEP))
        else $error("last token is not a separator");

    // a taken word token is followed straight away by its separator
    a_sep_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last && i_out_ready) |=> (r_valid && r_last))
        else $error("separator did not follow word token");

endmodule

`default_nettype wire

// ===== design/keyword_token_lexer_unit.sv =====
// keyword token lexer: one character per cycle in, word and separator tokens out
// a separator's first token passes through the queue into the output register
// throughput: one character per cycle while the queue has room; a separator after a
// word gives two tokens, absorbed by the four-entry queue between front and back
// reset: synchronous active-low i_rst_n empties word, bracket flag, queue and output
`timescale 1ns / 1ps
`default_nettype none

module keyword_token_lexer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_char_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [3:0]                         o_token_kind,
    output logic [2:0]                         o_token_index,
    output logic [kwtl_pkg::TEXT_W-1:0]        o_value_text,
    output logic [kwtl_pkg::LEN_W-1:0]         o_text_length,
    output logic                               o_too_long,
    output logic                               o_last
);
    import kwtl_pkg::*;

    t_push w_push;
    t_head w_head;
    logic  w_full;
    logic  w_pop;

    // character intake and classification
    kwtl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_char_in  (i_char_in),
        .i_q_full   (w_full),
        .o_in_ready (o_in_ready),
        .o_push     (w_push)
    );

    // decoupling queue
    kwtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // token output
    kwtl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_out_ready   (i_out_ready),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .o_token_kind  (o_token_kind),
        .o_token_index (o_token_index),
        .o_value_text  (o_value_text),
        .o_text_length (o_text_length),
        .o_too_long    (o_too_long),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ===== bench/kwtl_tb_pkg.sv =====
// token scoreboard for the keyword token lexer bench: expected token queue and
// a bit-true predictor of word and separator tokens; depends on kwtl_pkg
`timescale 1ns / 1ps

package kwtl_tb_pkg;

    import kwtl_pkg::*;

    localparam int KW_TOTAL = 20;

    // one token as it leaves the block
    typedef struct packed {
        logic [3:0]        kind;
        logic [2:0]        index;
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  length;
        logic              too_long;
        logic              is_last;
    } lex_token_t;

    class token_scoreboard;

        // keyword vocabulary with class and entry number
        string kw_words [KW_TOTAL] = '{
            "create", "draw", "binaryTree", "graph", "stack", "queue",
            "inorder", "preorder", "postorder", "add", "delete", "find", "push",
            "pop", "front", "back", "empty", "top", "node", "tree"
        };
        logic [3:0] kw_kinds [KW_TOTAL] = '{
            KIND_INITIAL, KIND_FINAL, KIND_DATA, KIND_DATA, KIND_DATA, KIND_DATA,
            KIND_ALGO, KIND_ALGO, KIND_ALGO, KIND_CMD_VAL, KIND_CMD_VAL,
            KIND_CMD_VAL, KIND_CMD_VAL, KIND_CMD_NVAL, KIND_CMD_NVAL,
            KIND_CMD_NVAL, KIND_CMD_NVAL, KIND_CMD_NVAL, KIND_KEYWORD, KIND_KEYWORD
        };
        logic [2:0] kw_entries [KW_TOTAL] = '{
            3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2,
            3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1
        };

        // predicted lexer state
        logic [7:0]  word_chars [MAX_WORD];
        int unsigned word_len;
        bit          dot_seen;
        bit          in_bracket;

        lex_token_t  expected_tokens [$];
        int unsigned mismatches;
        int unsigned tokens_checked;

        function new();
            word_len       = 0;
            dot_seen       = 0;
            in_bracket     = 0;
            mismatches     = 0;
            tokens_checked = 0;
        endfunction

        function int unsigned pending();
            return expected_tokens.size();
        endfunction

        // append one token to the expectation queue
        function void expect_token(lex_token_t tok);
            expected_tokens.insert(expected_tokens.size(), tok);
        endfunction

        // token for the buffered word under the current bracket state
        function lex_token_t classify_word();
            lex_token_t  tok;
            int unsigned len;
            bit          hit;
            tok          = '0;
            tok.too_long = (word_len > MAX_WORD);
            len          = tok.too_long ? MAX_WORD : word_len;
            tok.length   = len[LEN_W-1:0];
            if (in_bracket) begin
                tok.kind = dot_seen ? KIND_DOUBLE : KIND_INT;
                for (int i = 0; i < len && i < TEXT_BYTES; i++)
                    tok.text[8*i +: 8] = word_chars[i];
                return tok;
            end
            tok.kind = KIND_UNKNOWN;
            if (!tok.too_long) begin
                for (int k = 0; k < KW_TOTAL; k++) begin
                    if (kw_words[k].len() == len) begin
                        hit = 1;
                        for (int i = 0; i < len; i++)
                            if (kw_words[k][i] != word_chars[i]) hit = 0;
                        if (hit) begin
                            tok.kind  = kw_kinds[k];
                            tok.index = kw_entries[k];
                            return tok;
                        end
                    end
                end
            end
            return tok;
        endfunction

        // accepted character request: update state, queue any tokens it causes
        function void note_char(logic [7:0] c);
            lex_token_t sep_tok;
            bit         is_separator;
            is_separator = 1;
            sep_tok      = '0;
            sep_tok.kind    = KIND_SEP;
            sep_tok.is_last = 1'b1;
            case (c)
                CH_SEMI:  sep_tok.index = SEP_SEMI;
                CH_UNDER: sep_tok.index = SEP_UNDER;
                CH_OPEN:  sep_tok.index = SEP_OPEN;
                CH_CLOSE: sep_tok.index = SEP_CLOSE;
                CH_COMMA: sep_tok.index = SEP_COMMA;
                default:  is_separator = 0;
            endcase
            if (!is_separator) begin
                if (word_len < MAX_WORD) word_chars[word_len] = c;
                if (word_len <= MAX_WORD) word_len++;
                if (c == CH_DOT) dot_seen = 1;
                return;
            end
            // word is classified before the bracket state changes
            if (word_len != 0) expect_token(classify_word());
            word_len = 0;
            dot_seen = 0;
            if (sep_tok.index == SEP_OPEN) in_bracket = 1;
            else if (sep_tok.index == SEP_CLOSE) in_bracket = 0;
            expect_token(sep_tok);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at token %0d: %s", tokens_checked, msg);
        endtask

        task compare_field(string name, logic [63:0] got_v, logic [63:0] exp_v);
            if (got_v !== exp_v)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, exp_v));
        endtask

        // accepted token: compare with the oldest expectation
        task check_token(lex_token_t got);
            lex_token_t exp;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d index %0d",
                                          got.kind, got.index));
                return;
            end
            exp = expected_tokens.pop_front();
            compare_field("kind", 64'(got.kind), 64'(exp.kind));
            compare_field("index", 64'(got.index), 64'(exp.index));
            compare_field("text", got.text, exp.text);
            compare_field("length", 64'(got.length), 64'(exp.length));
            compare_field("too_long", 64'(got.too_long), 64'(exp.too_long));
            compare_field("last", 64'(got.is_last), 64'(exp.is_last));
            tokens_checked++;
        endtask

    endclass

endpackage

// ===== bench/tb_keyword_token_lexer_unit.sv =====
// bench top for keyword_token_lexer_unit: directed and random character streams
// under idle and stall phases, tokens checked by the scoreboard in kwtl_tb_pkg
`timescale 1ns / 1ps

module tb_keyword_token_lexer_unit;

    import kwtl_pkg::*;
    import kwtl_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 470;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [7:0]          i_char_in   = 8'h00;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [3:0]          o_token_kind;
    logic [2:0]          o_token_index;
    logic [TEXT_W-1:0]   o_value_text;
    logic [LEN_W-1:0]    o_text_length;
    logic                o_too_long;
    logic                o_last;

    token_scoreboard sb;
    lex_token_t      seen_token;
    logic [7:0]      char_plan [$];
    int unsigned     idle_pct  = 0;
    int unsigned     stall_pct = 0;
    int unsigned     cycle_count = 0;

    keyword_token_lexer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_token_kind  (o_token_kind),
        .o_token_index (o_token_index),
        .o_value_text  (o_value_text),
        .o_text_length (o_text_length),
        .o_too_long    (o_too_long),
        .o_last        (o_last)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // token receiver with random stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // token check on every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_token.kind     = o_token_kind;
            seen_token.index    = o_token_index;
            seen_token.text     = o_value_text;
            seen_token.length   = o_text_length;
            seen_token.too_long = o_too_long;
            seen_token.is_last  = o_last;
            sb.check_token(seen_token);
        end
    end

    // one character request, with random idle cycles ahead of it
    task send_char(input logic [7:0] c);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_char(c);
    endtask

    // hold the sender off until every expected token has come out
    task wait_for_tokens();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // append one character to the plan
    function automatic void add_char(input logic [7:0] c);
        char_plan.insert(char_plan.size(), c);
    endfunction

    task plan_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CH_SEMI;
            4, 5:       return CH_COMMA;
            6, 7:       return CH_UNDER;
            8:          return CH_OPEN;
            default:    return CH_CLOSE;
        endcase
    endfunction

    function automatic bit is_separator_char(input logic [7:0] c);
        return c == CH_SEMI || c == CH_UNDER || c == CH_OPEN || c == CH_CLOSE ||
               c == CH_COMMA;
    endfunction

    // word character: 0 digits and dots, 1 letters, 2 any byte but a separator
    function automatic logic [7:0] pick_word_char(input int mode);
        logic [7:0] c;
        case (mode)
            0: c = ($urandom_range(0, 7) == 0) ? CH_DOT : 8'($urandom_range(8'h30, 8'h39));
            1: c = 8'($urandom_range(8'h61, 8'h7A)) ^ ($urandom_range(0, 3) == 0 ? 8'h20 : 8'h00);
            default: begin
                c = 8'($urandom_range(0, 255));
                while (is_separator_char(c)) c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // value inside brackets: mostly short numbers, now and then long or odd
    task plan_value();
        int unsigned len;
        int          mode;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        mode = $urandom_range(0, 9);
        mode = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
        for (int i = 0; i < len; i++) add_char(pick_word_char(mode));
    endtask

    // one statement fragment of random content
    task plan_fragment();
        int unsigned pick;
        int unsigned n;
        string       w;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            plan_text(sb.kw_words[$urandom_range(0, KW_TOTAL - 1)]);
            add_char(pick_separator());
        end else if (pick < 60) begin
            add_char(CH_OPEN);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                if (i != 0) add_char(CH_COMMA);
                plan_value();
            end
            add_char(CH_CLOSE);
        end else if (pick < 75) begin
            // near miss of a keyword: cut, extended or one character case flipped
            w = sb.kw_words[$urandom_range(0, KW_TOTAL - 1)];
            case ($urandom_range(0, 2))
                0: w = w.substr(0, w.len() - 2);
                1: w = {w, string'(pick_word_char(1))};
                default: begin
                    n    = $urandom_range(0, w.len() - 1);
                    w[n] = w[n] ^ 8'h20;
                end
            endcase
            plan_text(w);
            add_char(pick_separator());
        end else if (pick < 85) begin
            n = $urandom_range(14, 20);
            for (int i = 0; i < n; i++) add_char(pick_word_char(2));
            add_char(pick_separator());
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)));
        end
    endtask

    task send_plan();
        while (char_plan.size() != 0) send_char(char_plan.pop_front());
    endtask

    task run_random(input int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            plan_fragment();
            if ($urandom_range(0, 49) == 0) wait_for_tokens();
            sent += char_plan.size();
            send_plan();
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: keyword, empty separator, word before '(', double and int
        // values, '(' inside brackets, ')' outside, control and high bytes
        plan_text("top;,pop(7.2(a)))");
        add_char(8'h00);
        add_char(8'hFF);
        add_char(CH_UNDER);
        send_plan();
        wait_for_tokens();

        // random phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 70; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            run_random(ITEMS_PER_PHASE);
            wait_for_tokens();
        end

        // drain, then let any stray token show up
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/kwtl_pkg.sv
design/kwtl_front.sv
design/kwtl_queue.sv
design/kwtl_back.sv
design/keyword_token_lexer_unit.sv
bench/kwtl_tb_pkg.sv
bench/tb_keyword_token_lexer_unit.sv
